FILE: hw/rtl/quadratic_root_solver_defines.svh
// Assertion macros shared by the solver's checker.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/qrs_pkg.sv
// Types, constants and helper functions of the quadratic root solver.
package qrs_pkg;

  localparam int CoefW     = 16;
  localparam int PartW     = 32;
  localparam int MagW      = 34;  // |b*b - 4ac| fits below 2^33
  localparam int RootW     = 17;  // isqrt of MagW bits
  localparam int NumW      = 18;  // signed numerator -b +/- s
  localparam int DvsW      = 17;  // |2a|
  localparam int QuoW      = 33;  // (|num| << 16) / |2a|
  localparam int FracW     = 16;
  localparam int SqrtSteps = 17;
  localparam int DivSteps  = 33;

  typedef enum logic [1:0] {
    KIND_DISTINCT = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_AZERO    = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic                    d_neg;
    logic                    d_zero;
  } sq_side_t;

  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  neg2;
  } div_side_t;

  // Apply sign to an unsigned quotient and clamp to the signed 32-bit range.
  function automatic logic [PartW-1:0] sat_part(input logic [QuoW-1:0] mag, input logic neg);
    logic [PartW-1:0] r;
    if (!neg) begin
      if (mag > QuoW'(33'h0_7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = mag[PartW-1:0];
    end else begin
      if (mag > QuoW'(33'h0_8000_0000)) r = 32'h8000_0000;
      else r = 32'd0 - mag[PartW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/quadratic_root_solver.sv
// Registered stages from input accept to result valid: discriminant, root, numerator,
//   divider and output stage.
// Throughput: one coefficient set per cycle; every stage of the root and divider pipelines
//   holds its own item, and one shared enable stalls them together.
// Reset (rst, synchronous, active high) clears the valid bit of every stage; data registers
//   keep whatever they held.
module quadratic_root_solver (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // [15:0] coef_quad, [31:16] coef_lin, [47:32] coef_const
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [31:0] root1_re, [63:32] root1_im, [95:64] root2_re,
                                  // [127:96] root2_im
  output logic [1:0]   m_tuser    // [1:0] root_kind
);

  localparam int CW = qrs_pkg::CoefW;
  localparam int NW = qrs_pkg::NumW;
  localparam int DW = qrs_pkg::DvsW;
  localparam int PW = qrs_pkg::PartW;

  // Whole pipeline moves when the output register is free or being drained.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Discriminant.
  logic                       dc_valid;
  logic [qrs_pkg::MagW-1:0]   dc_mag;
  qrs_pkg::sq_side_t          dc_side;

  qrs_disc u_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .a         (s_tdata[15:0]),
    .b         (s_tdata[31:16]),
    .c         (s_tdata[47:32]),
    .out_valid (dc_valid),
    .mag       (dc_mag),
    .side      (dc_side)
  );

  // Square root of |d|.
  logic                       sq_valid;
  logic [qrs_pkg::RootW-1:0]  sq_root;
  qrs_pkg::sq_side_t          sq_side;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dc_valid),
    .mag       (dc_mag),
    .in_side   (dc_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Numerator stage: pick the two dividends, split into magnitude and sign.
  // Real roots divide -b+s and -b-s; a complex pair divides -b and s.
  logic signed [NW-1:0] neg_b;
  logic signed [NW-1:0] s_ext;
  logic signed [NW-1:0] n1;
  logic signed [NW-1:0] n2;
  logic signed [NW-1:0] n1_abs;
  logic signed [NW-1:0] n2_abs;
  logic signed [DW-1:0] den;
  logic signed [DW-1:0] den_abs;
  qrs_pkg::kind_t       kind;

  assign neg_b   = NW'(0) - {{(NW-CW){sq_side.b[CW-1]}}, sq_side.b};
  assign s_ext   = {1'b0, sq_root};
  assign n1      = sq_side.d_neg ? neg_b : neg_b + s_ext;
  assign n2      = sq_side.d_neg ? s_ext : neg_b - s_ext;
  assign n1_abs  = n1[NW-1] ? NW'(0) - n1 : n1;
  assign n2_abs  = n2[NW-1] ? NW'(0) - n2 : n2;
  assign den     = {sq_side.a, 1'b0};
  assign den_abs = den[DW-1] ? DW'(0) - den : den;

  always_comb begin
    priority if (sq_side.a == '0) kind = qrs_pkg::KIND_AZERO;
    else if (sq_side.d_neg)       kind = qrs_pkg::KIND_COMPLEX;
    else if (sq_side.d_zero)      kind = qrs_pkg::KIND_DOUBLE;
    else                          kind = qrs_pkg::KIND_DISTINCT;
  end

  logic               nm_valid;
  logic [DW-1:0]      nm_mag1;
  logic [DW-1:0]      nm_mag2;
  logic [DW-1:0]      nm_dvs;
  qrs_pkg::div_side_t nm_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (en) begin
      nm_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_mag1      <= n1_abs[DW-1:0];
      nm_mag2      <= n2_abs[DW-1:0];
      nm_dvs       <= den_abs;
      nm_side.kind <= kind;
      nm_side.neg1 <= n1[NW-1] ^ den[DW-1];
      nm_side.neg2 <= n2[NW-1] ^ den[DW-1];
    end
  end

  // Divider: (|num| << 16) / |2a| for both lanes.
  logic                      dv_valid;
  logic [qrs_pkg::QuoW-1:0]  dv_q1;
  logic [qrs_pkg::QuoW-1:0]  dv_q2;
  qrs_pkg::div_side_t        dv_side;

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (nm_valid),
    .num1      (nm_mag1),
    .num2      (nm_mag2),
    .dvs       (nm_dvs),
    .in_side   (nm_side),
    .out_valid (dv_valid),
    .quo1      (dv_q1),
    .quo2      (dv_q2),
    .out_side  (dv_side)
  );

  // Output stage: sign, saturate and route the quotients.
  logic [PW-1:0] q1_sat;
  logic [PW-1:0] q2_sat;
  logic [PW-1:0] q2_neg_sat;
  logic [PW-1:0] r1_re_next;
  logic [PW-1:0] r1_im_next;
  logic [PW-1:0] r2_re_next;
  logic [PW-1:0] r2_im_next;

  assign q1_sat     = qrs_pkg::sat_part(dv_q1, dv_side.neg1);
  assign q2_sat     = qrs_pkg::sat_part(dv_q2, dv_side.neg2);
  assign q2_neg_sat = qrs_pkg::sat_part(dv_q2, !dv_side.neg2);

  always_comb begin
    unique case (dv_side.kind)
      qrs_pkg::KIND_COMPLEX: begin
        r1_re_next = q1_sat;
        r1_im_next = q2_sat;
        r2_re_next = q1_sat;
        r2_im_next = q2_neg_sat;
      end
      qrs_pkg::KIND_AZERO: begin
        r1_re_next = '0;
        r1_im_next = '0;
        r2_re_next = '0;
        r2_im_next = '0;
      end
      default: begin
        r1_re_next = q1_sat;
        r1_im_next = '0;
        r2_re_next = q2_sat;
        r2_im_next = '0;
      end
    endcase
  end

  // Output register: hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {r2_im_next, r2_re_next, r1_im_next, r1_re_next};
      m_tuser <= dv_side.kind;
    end
  end

endmodule

FILE: hw/rtl/qrs_disc.sv
// Two-stage discriminant unit: products, then b*b - 4ac and its magnitude.
module qrs_disc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qrs_pkg::CoefW-1:0]  a,
  input  logic signed [qrs_pkg::CoefW-1:0]  b,
  input  logic signed [qrs_pkg::CoefW-1:0]  c,
  output logic                              out_valid,
  output logic        [qrs_pkg::MagW-1:0]   mag,
  output qrs_pkg::sq_side_t                 side
);

  logic                      v1;
  logic signed [15:0]        a1;
  logic signed [15:0]        b1;
  logic signed [31:0]        bb;
  logic signed [31:0]        ac;
  logic signed [34:0]        d;
  logic signed [34:0]        nd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  assign d  = {{3{bb[31]}}, bb} - {ac[31], ac, 2'b00};
  assign nd = 35'sd0 - d;

  always_ff @(posedge clk) begin
    if (en) begin
      a1          <= a;
      b1          <= b;
      bb          <= b * b;
      ac          <= a * c;
      mag         <= d[34] ? nd[qrs_pkg::MagW-1:0] : d[qrs_pkg::MagW-1:0];
      side.a      <= a1;
      side.b      <= b1;
      side.d_neg  <= d[34];
      side.d_zero <= (d == 35'sd0);
    end
  end

endmodule

FILE: hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [qrs_pkg::MagW-1:0]         mag,
  input  qrs_pkg::sq_side_t                in_side,
  output logic                             out_valid,
  output logic [qrs_pkg::RootW-1:0]        root,
  output qrs_pkg::sq_side_t                out_side
);

  localparam int N = qrs_pkg::SqrtSteps;
  localparam int W = qrs_pkg::MagW;

  logic              vld  [0:N];
  logic [W-1:0]      rem  [0:N];
  logic [W-1:0]      res  [0:N];
  qrs_pkg::sq_side_t sd   [0:N];

  assign vld[0] = in_valid;
  assign rem[0] = mag;
  assign res[0] = '0;
  assign sd[0]  = in_side;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int K = N - 1 - j;
    localparam logic [W:0] BitV = (W+1)'(1) << (2 * K);
    logic [W:0] trial;
    logic       ge;

    assign trial = {1'b0, res[j]} + BitV;
    assign ge    = ({1'b0, rem[j]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? (rem[j] - trial[W-1:0]) : rem[j];
        res[j+1] <= ge ? ((res[j] >> 1) + BitV[W-1:0]) : (res[j] >> 1);
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N][qrs_pkg::RootW-1:0];
  assign out_side  = sd[N];

endmodule

FILE: hw/rtl/qrs_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
module qrs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [qrs_pkg::DvsW-1:0]         num1,
  input  logic [qrs_pkg::DvsW-1:0]         num2,
  input  logic [qrs_pkg::DvsW-1:0]         dvs,
  input  qrs_pkg::div_side_t               in_side,
  output logic                             out_valid,
  output logic [qrs_pkg::QuoW-1:0]         quo1,
  output logic [qrs_pkg::QuoW-1:0]         quo2,
  output qrs_pkg::div_side_t               out_side
);

  localparam int N  = qrs_pkg::DivSteps;
  localparam int QW = qrs_pkg::QuoW;
  localparam int DW = qrs_pkg::DvsW;

  logic               vld [0:N];
  logic [DW-1:0]      dv  [0:N];
  qrs_pkg::div_side_t sd  [0:N];
  logic [QW-1:0]      dd  [0:1][0:N];
  logic [DW-1:0]      rm  [0:1][0:N];
  logic [QW-1:0]      qq  [0:1][0:N];

  assign vld[0]   = in_valid;
  assign dv[0]    = dvs;
  assign sd[0]    = in_side;
  assign dd[0][0] = {num1, {qrs_pkg::FracW{1'b0}}};
  assign dd[1][0] = {num2, {qrs_pkg::FracW{1'b0}}};
  assign rm[0][0] = '0;
  assign rm[1][0] = '0;
  assign qq[0][0] = '0;
  assign qq[1][0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= dv[j];
        sd[j+1] <= sd[j];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;

      assign trial = {rm[l][j], dd[l][j][QW-1]};
      assign diff  = trial - {1'b0, dv[j]};
      assign ge    = (trial >= {1'b0, dv[j]});

      always_ff @(posedge clk) begin
        if (en) begin
          rm[l][j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          dd[l][j+1] <= dd[l][j] << 1;
          qq[l][j+1] <= {qq[l][j][QW-2:0], ge};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign quo1      = qq[0][N];
  assign quo2      = qq[1][N];
  assign out_side  = sd[N];

endmodule

FILE: hw/rtl/qrs_check.sv
// Port-level checker for the quadratic root solver, bound to the top level.
`include "quadratic_root_solver_defines.svh"

module qrs_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [1:0]   m_tuser
);

  `QRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result dropped or changed under stall")
  `QRS_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready, "input refused while the output register is empty")
  `QRS_ASSERT_NOW(a_azero_zero, m_tvalid && (m_tuser == qrs_pkg::KIND_AZERO), m_tdata == '0, "zero a must give all-zero parts")
  `QRS_ASSERT_NOW(a_real_no_im, m_tvalid && ((m_tuser == qrs_pkg::KIND_DISTINCT) || (m_tuser == qrs_pkg::KIND_DOUBLE)), (m_tdata[63:32] == '0) && (m_tdata[127:96] == '0), "real roots carry an imaginary part")
  `QRS_ASSERT_NOW(a_same_re, m_tvalid && ((m_tuser == qrs_pkg::KIND_DOUBLE) || (m_tuser == qrs_pkg::KIND_COMPLEX)), m_tdata[31:0] == m_tdata[95:64], "real parts differ for double or complex roots")

endmodule

bind quadratic_root_solver qrs_check u_qrs_check (.*);

FILE: dv/quadratic_root_solver_checker.sv
// Checker for the quadratic root solver: predicts each result and compares it.
module quadratic_root_solver_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [47:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic [1:0]   m_tuser,
  output int           fail_count,
  output int           pending,
  output int           seen_kinds [4]
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] r2_im;
    logic [31:0] r2_re;
    logic [31:0] r1_im;
    logic [31:0] r1_re;
  } roots_t;

  roots_t expected_roots[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(input longint q);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // SystemVerilog division truncates toward zero, as the hardware must.
  function automatic roots_t solve_roots(input logic [47:0] coefs);
    longint a, b, c, den, disc, s, re, im;
    roots_t r;
    a = longint'($signed(coefs[15:0]));
    b = longint'($signed(coefs[31:16]));
    c = longint'($signed(coefs[47:32]));
    r = '0;
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_AZERO;
      return r;
    end
    den = 2 * a;
    disc = b * b - 4 * a * c;
    s = longint'(int_sqrt(disc < 0 ? -disc : disc));
    if (disc >= 0) begin
      r.r1_re = clamp32(((-b + s) * 65536) / den);
      r.r2_re = clamp32(((-b - s) * 65536) / den);
      r.kind = (disc > 0) ? qrs_pkg::KIND_DISTINCT : qrs_pkg::KIND_DOUBLE;
    end else begin
      re = (-b * 65536) / den;
      im = (s * 65536) / den;
      r.r1_re = clamp32(re);
      r.r2_re = clamp32(re);
      r.r1_im = clamp32(im);
      r.r2_im = clamp32(-im);
      r.kind = qrs_pkg::KIND_COMPLEX;
    end
    return r;
  endfunction

  assign pending = expected_roots.size();

  initial begin
    fail_count = 0;
    for (int k = 0; k < 4; k++) seen_kinds[k] = 0;
  end

  always @(posedge clk) begin
    roots_t exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_roots.push_back(solve_roots(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_roots.size() == 0) begin
          $error("result with no expectation waiting: %h %h", m_tdata, m_tuser);
          fail_count++;
        end else begin
          exp_r = expected_roots.pop_front();
          seen_kinds[exp_r.kind]++;
          if (m_tdata[31:0] !== exp_r.r1_re) begin
            $error("root1_re expected %h actual %h", exp_r.r1_re, m_tdata[31:0]);
            fail_count++;
          end
          if (m_tdata[63:32] !== exp_r.r1_im) begin
            $error("root1_im expected %h actual %h", exp_r.r1_im, m_tdata[63:32]);
            fail_count++;
          end
          if (m_tdata[95:64] !== exp_r.r2_re) begin
            $error("root2_re expected %h actual %h", exp_r.r2_re, m_tdata[95:64]);
            fail_count++;
          end
          if (m_tdata[127:96] !== exp_r.r2_im) begin
            $error("root2_im expected %h actual %h", exp_r.r2_im, m_tdata[127:96]);
            fail_count++;
          end
          if (m_tuser !== exp_r.kind) begin
            $error("root_kind expected %0d actual %0d", exp_r.kind, m_tuser);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: dv/quadratic_root_solver_tb.sv
// Testbench top for the quadratic root solver: stimulus, back pressure and verdict.
module quadratic_root_solver_tb;

  localparam int RandomSets = 1300;
  localparam int LatencyCycles = 54;
  localparam int CycleLimit = 200000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;   // [15:0] coef_quad, [31:16] coef_lin, [47:32] coef_const
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // root1_re, root1_im, root2_re, root2_im from bit 0 up
  logic [1:0]   m_tuser;        // [1:0] root_kind
  int           fail_count;
  int           pending;
  int           seen_kinds [4];
  int           cycle_count = 0;
  bit           quiet_phase = 1'b0;  // no idling on either side while set

  always #2 clk = ~clk;

  quadratic_root_solver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  quadratic_root_solver_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending), .seen_kinds(seen_kinds)
  );

  // Stall the result side at random, about 15 percent of the time, except during the quiet stretch.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet_phase || ($urandom_range(99) >= 15);
  end

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one coefficient set: idle first at random, then hold valid until accepted.
  task automatic send_coefs(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
    while (!quiet_phase && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Pick a coefficient: mostly full range, sometimes extremes or small values.
  function automatic logic [15:0] pick_coef();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h8000;
    if (sel == 1) return 16'h7FFF;
    if (sel == 2) return 16'h0000;
    if (sel < 5) return 16'($signed($urandom_range(1024)) - 512);
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] a, b, c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero a, extremes, each root kind, saturation.
    send_coefs(16'h0000, 16'h1234, 16'h5678);       // a is zero
    send_coefs(16'h0000, 16'h8000, 16'h7FFF);
    send_coefs(16'h0100, 16'hFD00, 16'h0200);       // x^2-3x+2: distinct
    send_coefs(16'h0100, 16'hFE00, 16'h0100);       // x^2-2x+1: double
    send_coefs(16'h0100, 16'h0000, 16'h0100);       // x^2+1: complex
    send_coefs(16'h0100, 16'h0000, 16'h0000);       // double at zero
    send_coefs(16'h0001, 16'h7FFF, 16'h0000);       // tiny a, huge root, just inside the range
    send_coefs(16'hFFFF, 16'h7FFF, 16'h0000);
    send_coefs(16'h0001, 16'h0000, 16'h7FFF);       // complex, zero real part
    send_coefs(16'h0001, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_coefs(16'h8000, 16'h7FFF, 16'h7FFF);
    send_coefs(16'h7FFF, 16'h8000, 16'h8000);
    send_coefs(16'hFF00, 16'h0300, 16'hFE00);       // negative a, distinct
    send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_coefs(16'h0001, 16'h0002, 16'h0001);       // double, tiny
    send_coefs(16'h5555, 16'hAAAA, 16'h5555);

    // Random sets; a quiet stretch in the middle drops all idling.
    for (int i = 0; i < RandomSets; i++) begin
      quiet_phase = (i >= 500 && i < 700);
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      send_coefs(a, b, c);
    end
    quiet_phase = 1'b0;
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LatencyCycles + 10) @(posedge clk);

    $display("Checked %0d coefficient sets plus directed cases.", RandomSets);
    $display("Kinds seen: distinct %0d, double %0d, complex %0d, zero a %0d",
             seen_kinds[qrs_pkg::KIND_DISTINCT], seen_kinds[qrs_pkg::KIND_DOUBLE],
             seen_kinds[qrs_pkg::KIND_COMPLEX], seen_kinds[qrs_pkg::KIND_AZERO]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
